// ===== sv/assert_macros.svh =====
// Assertion macros shared by the event-time safety counter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/etsc_pkg.sv =====
// Types and constants for the event-time safety counter.
// No dependencies; used by etsc_store and event_time_safety_counter_core.
package etsc_pkg;

   localparam int TIME_W   = 64;
   localparam int REGION_W = 16;
   localparam int CORE_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int LA_W     = 32;
   localparam int MODE_W   = 2;

   localparam logic [TIME_W-1:0]   INFTY      = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [REGION_W-1:0] REGION_RST = '0;

   // action codes
   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   // check modes; the unused code behaves as MODE_REGION
   localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKAHEAD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REGION    = 2'd2;

   // register select, paddr bit 2
   localparam logic REG_LOOKAHEAD  = 1'b0;
   localparam logic REG_CHECK_MODE = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]   evt_time;
      logic [REGION_W-1:0] region;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } wr_req_type;

endpackage

// ===== sv/etsc_store.sv =====
// Per-core timestamp/region store: one write port, one registered read port.
// Per-entry valid bits stand in for the reset contents. Uses etsc_pkg.
module etsc_store #(
   parameter int NUM_CORES = 16,
   localparam int IDX_W = $clog2(NUM_CORES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  etsc_pkg::wr_req_type  wr,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output etsc_pkg::entry_type   rd_data
);

   etsc_pkg::entry_type store_ff [NUM_CORES];
   logic [NUM_CORES-1:0] valid_ff;
   etsc_pkg::entry_type  rd_raw_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_raw_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries read as infinity / region zero
   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_raw_ff;
      end else begin
         rd_data.evt_time = etsc_pkg::INFTY;
         rd_data.region   = etsc_pkg::REGION_RST;
      end
   end

endmodule

// ===== sv/event_time_safety_counter_core.sv =====
// Event-time safety counter. A record transaction (tuser 0) stores a core's
// timestamp and region and returns a zero count in the next cycle. A check
// transaction (tuser 1) scans every core entry through the single read port
// of the store, one entry per cycle, then two compare stages; the next
// transaction is taken the cycle the result register frees up. Records run
// at one per cycle while the response side keeps accepting.
// Depends on etsc_pkg, etsc_store and assert_macros.svh.
`include "assert_macros.svh"

module event_time_safety_counter_core #(
   parameter int NUM_CORES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = core_id[3:0], event_time[67:4], region[83:68], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,
   input  logic        req_tuser,   // action
   // response: tdata = blocking_count[4:0], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(NUM_CORES);
   localparam int CMP_W = IDX_W + etsc_pkg::CORE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CORES - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   // request fields
   logic                                req_action;
   logic [etsc_pkg::CORE_W-1:0]         req_core_id;
   logic [etsc_pkg::TIME_W-1:0]         req_event_time;
   logic [etsc_pkg::REGION_W-1:0]       req_region;
   assign req_action     = req_tuser;
   assign req_core_id    = req_tdata[3:0];
   assign req_event_time = req_tdata[67:4];
   assign req_region     = req_tdata[83:68];

   // configuration
   logic [etsc_pkg::LA_W-1:0]   lookahead_ff;
   logic [etsc_pkg::MODE_W-1:0] mode_ff;
   logic                        csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == etsc_pkg::REG_CHECK_MODE) ?
                       32'(mode_ff) : lookahead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookahead_ff <= '0;
         mode_ff      <= etsc_pkg::MODE_REGION;
      end else if (csr_wr) begin
         if (csr_paddr[2] == etsc_pkg::REG_LOOKAHEAD) begin
            lookahead_ff <= csr_pwdata;
         end else begin
            mode_ff <= csr_pwdata[etsc_pkg::MODE_W-1:0];
         end
      end
   end

   // control and pipeline registers
   logic [1:0]                    state_ff, state_in;
   logic [IDX_W-1:0]              addr_ff, addr_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic                          rd_last_ff, rd_last_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                          s2_vld_ff, s2_vld_in;
   logic                          s2_last_ff, s2_last_in;
   logic                          s2_self_ff, s2_self_in;
   logic                          s2_me_gt_ff, s2_me_gt_in;
   logic                          s2_reg_eq_ff, s2_reg_eq_in;
   logic [etsc_pkg::TIME_W-1:0]   s2_ti_ff, s2_ti_in;
   logic [etsc_pkg::TIME_W-1:0]   s2_tl_ff, s2_tl_in;
   logic [etsc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [etsc_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [etsc_pkg::CORE_W-1:0]   me_ff, me_in;
   logic [etsc_pkg::TIME_W-1:0]   t_ff, t_in;
   logic [etsc_pkg::REGION_W-1:0] reg_ff, reg_in;

   logic                          req_acc;
   logic                          scan_last;
   etsc_pkg::wr_req_type          wr;
   etsc_pkg::entry_type           rd_data;
   logic [etsc_pkg::TIME_W:0]     la_sum;
   logic                          plain_hit, la_hit, hit;
   logic [etsc_pkg::COUNT_W-1:0]  count_next;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;
   assign scan_last  = (addr_ff == LAST_IDX);

   assign wr.en            = req_acc && (req_action == etsc_pkg::ACT_RECORD) &&
                             (CMP_W'(req_core_id) < CMP_W'(NUM_CORES));
   assign wr.data.evt_time = req_event_time;
   assign wr.data.region   = req_region;

   etsc_store #(
      .NUM_CORES (NUM_CORES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (IDX_W'(req_core_id)),
      .rd_en   (state_ff == S_SCAN),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // stage 2 arithmetic: saturating lookahead add
   assign la_sum = {1'b0, rd_data.evt_time} +
                   (etsc_pkg::TIME_W + 1)'(lookahead_ff);

   // stage 3: blocking tests and count
   assign plain_hit = (t_ff > s2_ti_ff) || ((t_ff == s2_ti_ff) && s2_me_gt_ff);
   assign la_hit    = (t_ff > s2_tl_ff) || ((t_ff == s2_tl_ff) && s2_me_gt_ff);

   always_comb begin
      case (mode_ff)
         etsc_pkg::MODE_PLAIN:     hit = plain_hit;
         etsc_pkg::MODE_LOOKAHEAD: hit = la_hit;
         default:                  hit = la_hit || (s2_reg_eq_ff && plain_hit);
      endcase
   end

   assign count_next = (hit && !s2_self_ff && (count_ff != etsc_pkg::COUNT_MAX)) ?
                       count_ff + 1'b1 : count_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      me_in        = me_ff;
      t_in         = t_ff;
      reg_in       = reg_ff;
      count_in     = count_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;

      rd_vld_in    = (state_ff == S_SCAN);
      rd_last_in   = scan_last;
      rd_idx_in    = addr_ff;

      s2_vld_in    = rd_vld_ff;
      s2_last_in   = rd_last_ff;
      s2_self_in   = (CMP_W'(rd_idx_ff) == CMP_W'(me_ff));
      s2_me_gt_in  = (CMP_W'(me_ff) > CMP_W'(rd_idx_ff));
      s2_reg_eq_in = (rd_data.region == reg_ff);
      s2_ti_in     = rd_data.evt_time;
      s2_tl_in     = la_sum[etsc_pkg::TIME_W] ? etsc_pkg::INFTY :
                     la_sum[etsc_pkg::TIME_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_action == etsc_pkg::ACT_CHECK) begin
                  state_in = S_SCAN;
                  addr_in  = '0;
                  count_in = '0;
                  me_in    = req_core_id;
                  t_in     = req_event_time;
                  reg_in   = req_region;
               end else begin
                  rsp_vld_in   = 1'b1;
                  rsp_count_in = '0;
               end
            end
         end
         S_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (s2_vld_ff) begin
         count_in = count_next;
         if (s2_last_ff) begin
            rsp_vld_in   = 1'b1;
            rsp_count_in = count_next;
            state_in     = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      me_ff        <= me_in;
      t_ff         <= t_in;
      reg_ff       <= reg_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rd_last_ff   <= rd_last_in;
      rd_idx_ff    <= rd_idx_in;
      s2_last_ff   <= s2_last_in;
      s2_self_ff   <= s2_self_in;
      s2_me_gt_ff  <= s2_me_gt_in;
      s2_reg_eq_ff <= s2_reg_eq_in;
      s2_ti_ff     <= s2_ti_in;
      s2_tl_ff     <= s2_tl_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = 8'(rsp_count_ff);

   // scan result must never land on an occupied response register
   `ASSERT_IMPL(a_drain_free, clock, reset, s2_vld_ff && s2_last_ff, !rsp_vld_ff, "scan result overwrites pending response")
   // compare pipeline only carries entries while a check is in flight
   `ASSERT_IMPL(a_pipe_busy, clock, reset, s2_vld_ff || rd_vld_ff, state_ff != S_IDLE, "pipeline active while idle")
   // an accepted check starts the scan at entry zero
   `ASSERT_NEXT(a_check_start, clock, reset, req_acc && (req_action == etsc_pkg::ACT_CHECK), (state_ff == S_SCAN) && (addr_ff == '0), "check did not start scan")
   // a record answers on the next cycle
   `ASSERT_NEXT(a_record_rsp, clock, reset, req_acc && (req_action == etsc_pkg::ACT_RECORD), rsp_vld_ff && (rsp_count_ff == '0), "record response missing")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for event_time_safety_counter_core: record and check
// transactions on the request stream, counts checked against a local predictor.
// Depends on etsc_pkg and the core RTL only.
module testbench;

   localparam int           CORES      = 16;
   localparam int           ITEMS      = 450;
   localparam int           PHASES     = 6;
   localparam int           STALL_MAX  = 5000;
   localparam logic [1:0]   MODE_UNUSED = 2'd3;
   localparam logic [5:0]   PREDICT    = 6'h3F;
   localparam logic [2:0]   ADDR_LOOKAHEAD  = {etsc_pkg::REG_LOOKAHEAD, 2'b00};
   localparam logic [2:0]   ADDR_CHECK_MODE = {etsc_pkg::REG_CHECK_MODE, 2'b00};

   typedef struct packed {
      logic                          set_csr;
      logic [etsc_pkg::LA_W-1:0]     la;
      logic [etsc_pkg::MODE_W-1:0]   mode;
      logic                          action;
      logic [etsc_pkg::CORE_W-1:0]   core;
      logic [etsc_pkg::TIME_W-1:0]   stamp;
      logic [etsc_pkg::REGION_W-1:0] region;
      logic [5:0]                    want;     // PREDICT: take the count from the predictor
   } plan_row_type;

   // directed plan; state after reset is every core at infinity, region 0
   localparam plan_row_type PLAN [21] = '{
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd0, 64'd0, 16'h0000,
        6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd15, etsc_pkg::INFTY,
        16'hFFFF, 6'd15},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd7, etsc_pkg::INFTY,
        16'h0000, 6'd7},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_RECORD, 4'd0, 64'd0, 16'h0000,
        6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_RECORD, 4'd15,
        64'h8000_0000_0000_0000, 16'hFFFF, 6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_RECORD, 4'd5, 64'd100, 16'h0003,
        6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_RECORD, 4'd6, 64'd100, 16'h0004,
        6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd3, 64'd100, 16'h0003,
        PREDICT},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd9, 64'd100, 16'h0004,
        PREDICT},
      '{1'b1, 32'd0, etsc_pkg::MODE_PLAIN, etsc_pkg::ACT_CHECK, 4'd8, 64'd100, 16'h0007,
        PREDICT},
      '{1'b1, 32'hFFFF_FFFF, etsc_pkg::MODE_LOOKAHEAD, etsc_pkg::ACT_RECORD, 4'd1,
        etsc_pkg::INFTY - 64'd5, 16'h0001, 6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd2, etsc_pkg::INFTY,
        16'h0001, PREDICT},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd14,
        etsc_pkg::INFTY - 64'd1, 16'h0000, PREDICT},
      '{1'b1, 32'd50, etsc_pkg::MODE_REGION, etsc_pkg::ACT_RECORD, 4'd2, 64'd130, 16'h0003,
        6'd0},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd4, 64'd120, 16'h0003,
        PREDICT},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd4, 64'd120, 16'h0009,
        PREDICT},
      '{1'b1, 32'd50, MODE_UNUSED, etsc_pkg::ACT_CHECK, 4'd4, 64'd120, 16'h0003, PREDICT},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd10,
        64'hFFFF_FFFF_0000_0000, 16'hAAAA, PREDICT},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_RECORD, 4'd15, etsc_pkg::INFTY,
        16'h0000, 6'd0},
      '{1'b1, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd0,
        64'h5555_5555_5555_5555, 16'h5555, PREDICT},
      '{1'b0, 32'd0, etsc_pkg::MODE_REGION, etsc_pkg::ACT_CHECK, 4'd15, etsc_pkg::INFTY,
        16'h0000, PREDICT}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;    // core_id[3:0], event_time[67:4], region[83:68], zero fill
   logic        req_tuser;    // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // blocking_count[4:0], zero fill
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the block state
   logic [etsc_pkg::TIME_W-1:0]   slot_time   [CORES];
   logic [etsc_pkg::REGION_W-1:0] slot_region [CORES];
   logic [etsc_pkg::LA_W-1:0]     la_window;
   logic [etsc_pkg::MODE_W-1:0]   mode_sel;

   logic [etsc_pkg::COUNT_W-1:0]  pending_counts [$];
   int                            mismatches = 0;
   int                            idle_cycles = 0;
   bit                            no_idle = 1'b0;

   event_time_safety_counter_core #(.NUM_CORES(CORES)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic outranks(input logic [etsc_pkg::TIME_W-1:0] mine,
                                     input logic [etsc_pkg::TIME_W-1:0] theirs,
                                     input logic [etsc_pkg::CORE_W-1:0] asker,
                                     input int idx);
      return (mine > theirs) || (mine == theirs && int'(asker) > idx);
   endfunction

   function automatic logic [etsc_pkg::COUNT_W-1:0] count_blockers(
         input logic [etsc_pkg::CORE_W-1:0]   asker,
         input logic [etsc_pkg::TIME_W-1:0]   stamp,
         input logic [etsc_pkg::REGION_W-1:0] region);
      logic [etsc_pkg::TIME_W:0]    widened;
      logic [etsc_pkg::TIME_W-1:0]  shifted;
      logic                         hit;
      logic [etsc_pkg::COUNT_W-1:0] hits;
      int                           i;
      hits = '0;
      for (i = 0; i < CORES; i++) begin
         if (i != int'(asker)) begin
            // lookahead sum saturates at infinity
            widened = {1'b0, slot_time[i]} +
                      {{(etsc_pkg::TIME_W-etsc_pkg::LA_W+1){1'b0}}, la_window};
            shifted = widened[etsc_pkg::TIME_W] ? etsc_pkg::INFTY :
                      widened[etsc_pkg::TIME_W-1:0];
            case (mode_sel)
               etsc_pkg::MODE_PLAIN:     hit = outranks(stamp, slot_time[i], asker, i);
               etsc_pkg::MODE_LOOKAHEAD: hit = outranks(stamp, shifted, asker, i);
               default:                  hit = outranks(stamp, shifted, asker, i) ||
                                               (region == slot_region[i] &&
                                                outranks(stamp, slot_time[i], asker, i));
            endcase
            if (hit && hits < etsc_pkg::COUNT_MAX)
               hits++;
         end
      end
      return hits;
   endfunction

   // times cluster around stored ones so that ties and near misses are common
   function automatic logic [etsc_pkg::TIME_W-1:0] pick_stamp();
      logic [etsc_pkg::TIME_W-1:0] base;
      base = slot_time[$urandom_range(0, CORES-1)];
      case ($urandom_range(0, 9))
         0:       return etsc_pkg::INFTY;
         1:       return etsc_pkg::INFTY - 64'($urandom_range(0, 3));
         2:       return {$urandom, $urandom};
         3:       return 64'($urandom_range(0, 200));
         default: return base + 64'($urandom_range(0, 120)) - 64'd60;
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic send_item(input logic action, input logic [etsc_pkg::CORE_W-1:0] core,
                            input logic [etsc_pkg::TIME_W-1:0] stamp,
                            input logic [etsc_pkg::REGION_W-1:0] region,
                            input logic [5:0] want);
      logic [etsc_pkg::COUNT_W-1:0] predicted;
      while (!no_idle && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0, region, stamp, core};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (action == etsc_pkg::ACT_CHECK) begin
         predicted = count_blockers(core, stamp, region);
      end else begin
         predicted         = '0;
         slot_time[core]   = stamp;
         slot_region[core] = region;
      end
      pending_counts.push_back(want == PREDICT ? predicted : want[etsc_pkg::COUNT_W-1:0]);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // registers change only once every outstanding count has come back
   task automatic apply_settings(input logic [etsc_pkg::LA_W-1:0] la,
                                 input logic [etsc_pkg::MODE_W-1:0] mode);
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0)
         @(negedge clock);
      write_csr(ADDR_LOOKAHEAD, la);
      write_csr(ADDR_CHECK_MODE, {{(32-etsc_pkg::MODE_W){1'b0}}, mode});
      la_window = la;
      mode_sel  = mode;
   endtask

   always @(negedge clock)
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 15);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            $error("unexpected result transaction: blocking_count %0d",
                   rsp_tdata[etsc_pkg::COUNT_W-1:0]);
            mismatches++;
         end else if (rsp_tdata[etsc_pkg::COUNT_W-1:0] != pending_counts[0]) begin
            $error("blocking_count mismatch: expected %0d, got %0d",
                   pending_counts[0], rsp_tdata[etsc_pkg::COUNT_W-1:0]);
            mismatches++;
            void'(pending_counts.pop_front());
         end else begin
            void'(pending_counts.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("[event_time_safety_counter_core] ERROR");
         $finish;
      end
   end

   initial begin
      int                            row;
      int                            phase;
      int                            k;
      int                            idx;
      logic [etsc_pkg::LA_W-1:0]     la;
      logic [etsc_pkg::MODE_W-1:0]   mode;
      logic                          action;
      logic [etsc_pkg::CORE_W-1:0]   core;
      logic [etsc_pkg::REGION_W-1:0] region;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (k = 0; k < CORES; k++) begin
         slot_time[k]   = etsc_pkg::INFTY;
         slot_region[k] = etsc_pkg::REGION_RST;
      end
      la_window = '0;
      mode_sel  = etsc_pkg::MODE_REGION;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < $size(PLAN); row++) begin
         if (PLAN[row].set_csr)
            apply_settings(PLAN[row].la, PLAN[row].mode);
         send_item(PLAN[row].action, PLAN[row].core, PLAN[row].stamp,
                   PLAN[row].region, PLAN[row].want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               la = '0;
               mode = etsc_pkg::MODE_PLAIN;
            end
            1: begin
               la = 32'hFFFF_FFFF;
               mode = etsc_pkg::MODE_LOOKAHEAD;
            end
            2: begin
               la = 32'($urandom_range(1, 80));
               mode = etsc_pkg::MODE_REGION;
            end
            3: begin
               la = $urandom;
               mode = MODE_UNUSED;
            end
            4: begin
               la = 32'($urandom_range(1, 80));
               mode = etsc_pkg::MODE_LOOKAHEAD;
            end
            default: begin
               la = '0;
               mode = etsc_pkg::MODE_REGION;
            end
         endcase
         apply_settings(la, mode);
         for (k = 0; k < ITEMS / PHASES; k++) begin
            idx     = phase * (ITEMS / PHASES) + k;
            no_idle = (idx >= 150 && idx < 250);
            action  = $urandom_range(0, 1) ? etsc_pkg::ACT_CHECK : etsc_pkg::ACT_RECORD;
            core    = etsc_pkg::CORE_W'($urandom_range(0, CORES-1));
            region  = ($urandom_range(0, 4) == 0) ?
                      etsc_pkg::REGION_W'($urandom) :
                      etsc_pkg::REGION_W'($urandom_range(0, 3));
            send_item(action, core, pick_stamp(), region, PREDICT);
         end
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0)
         @(negedge clock);
      repeat (CORES + 8) @(posedge clock);

      if (mismatches == 0)
         $display("[event_time_safety_counter_core] OK");
      else
         $display("[event_time_safety_counter_core] ERROR");
      $finish;
   end

endmodule
